// ===== rtl/byte_to_multitone_synth_top_assert.svh =====
// Assertion macros shared by the synthesiser RTL.
`ifndef BYTE_TO_MULTITONE_SYNTH_TOP_ASSERT_SVH
`define BYTE_TO_MULTITONE_SYNTH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btm check failed");
// Next-cycle implication, checked out of reset.
`define BTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btm check failed");
`else
`define BTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/btm_pkg.sv =====
package btm_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               byte_done;
    } t_out;

    localparam int NUM_TONES = 8;

    // Pipeline stage positions
    localparam int ST_IN       = 0;
    localparam int ST_TONE     = 1;
    localparam int ST_SINE     = 2;
    localparam int SINE_STAGES = 5;
    localparam int ST_SUM      = 7;
    localparam int ST_GAIN     = 8;
    localparam int ST_OUT      = 9;
    localparam int NUM_STAGES  = 10;
    localparam int MIX_STAGES  = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_GAIN = 2'd1;
    localparam logic [1:0] CFG_SPB  = 2'd2;

    localparam logic [31:0] STEP_RESET = 32'd0;
    localparam logic [15:0] GAIN_RESET = 16'd23198;
    localparam logic [23:0] SPB_RESET  = 24'd44100;

    // Quarter-wave polynomial coefficients, Q15
    localparam logic [23:0] SINE_K0 = 24'd153;
    localparam logic [11:0] SINE_K1 = 12'd2611;
    localparam logic [14:0] SINE_K2 = 15'd21167;
    localparam logic [15:0] SINE_K3 = 16'd51472;
    localparam logic [16:0] SINE_MAX = 17'd32767;

    localparam int SUM_W  = 19;
    localparam int ABS_W  = 18;
    localparam int MAG_W  = 16;
    localparam int GAIN_SHIFT = 18;

    localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;

endpackage

// ===== rtl/btm_front.sv =====
module btm_front #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int COUNT_BITS     = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [1:0]                            i_en,
    input  btm_pkg::t_in                          i_in,
    input  logic [31:0]                           i_step,
    input  logic [23:0]                           i_spb,
    output logic [btm_pkg::NUM_TONES-1:0][15:0]   o_x,
    output logic [btm_pkg::NUM_TONES-1:0]         o_neg,
    output logic                                  o_done
);

    localparam int PROD_W  = PHASE_BITS + 6;
    localparam int X_SHIFT = 17 - SINE_ADDR_BITS;
    localparam logic [SINE_ADDR_BITS-2:0] QUARTER = (SINE_ADDR_BITS-1)'(1) << (SINE_ADDR_BITS-2);

    logic [PHASE_BITS-1:0] r_base;
    logic [COUNT_BITS-1:0] r_slot;
    logic [PHASE_BITS-1:0] r_bp;
    logic [7:0]            r_byte;
    logic                  r_done;
    logic [btm_pkg::NUM_TONES-1:0][15:0] r_x;
    logic [btm_pkg::NUM_TONES-1:0]       r_neg;
    logic                  r_done1;

    logic [PHASE_BITS-1:0] w_bp;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] w_len;
    logic [COUNT_BITS:0]   w_next;
    logic                  w_done;
    logic [btm_pkg::NUM_TONES-1:0][15:0] n_x;
    logic [btm_pkg::NUM_TONES-1:0]       n_neg;

    // Restart zeroes the state before this request's sample is made.
    always_comb begin
        w_bp   = i_in.restart ? '0 : r_base;
        w_cnt  = i_in.restart ? '0 : r_slot;
        w_len  = COUNT_BITS'(i_spb);
        if (w_len == '0) begin
            w_len = COUNT_BITS'(1);
        end
        w_next = {1'b0, w_cnt} + (COUNT_BITS+1)'(1);
        w_done = (w_next >= {1'b0, w_len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_slot <= '0;
        end else if (i_accept) begin
            r_base <= w_bp + PHASE_BITS'(i_step);
            r_slot <= w_done ? '0 : w_next[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_bp   <= w_bp;
            r_byte <= i_in.data_byte;
            r_done <= w_done;
        end
    end

    // Tone phase is (3 + 2m) times the base phase; fold it into a quarter-wave position.
    always_comb begin
        logic [5:0]                mult;
        logic [PROD_W-1:0]         prod;
        logic [PHASE_BITS-1:0]     ph;
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [SINE_ADDR_BITS-2:0] pos;
        n_x   = '0;
        n_neg = '0;
        for (int r = 0; r < btm_pkg::NUM_TONES; r++) begin
            mult = 6'(4 * r + 3) + {4'd0, r_byte[7 - r], 1'b0};
            prod = PROD_W'(r_bp) * PROD_W'(mult);
            ph   = prod[PHASE_BITS-1:0];
            addr = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
            pos  = {1'b0, addr[SINE_ADDR_BITS-3:0]};
            if (addr[SINE_ADDR_BITS-2]) begin
                pos = QUARTER - pos;
            end
            n_x[r]   = 16'(pos) << X_SHIFT;
            n_neg[r] = addr[SINE_ADDR_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x     <= n_x;
            r_neg   <= n_neg;
            r_done1 <= r_done;
        end
    end

    assign o_x    = r_x;
    assign o_neg  = r_neg;
    assign o_done = r_done1;

`include "byte_to_multitone_synth_top_assert.svh"

    `BTM_ASSERT_NXT(a_restart_zero, i_clk, i_rst_n, i_accept && i_in.restart, r_bp == '0)
    `BTM_ASSERT_NXT(a_unit_slot_done, i_clk, i_rst_n, i_accept && (w_len == COUNT_BITS'(1)), r_done)

endmodule

// ===== rtl/btm_sine.sv =====
module btm_sine (
    input  logic                              i_clk,
    input  logic [btm_pkg::SINE_STAGES-1:0]   i_en,
    input  logic [15:0]                       i_x,
    input  logic                              i_neg,
    output logic signed [16:0]                o_s
);

    logic [15:0] r_x2_a, r_x2_b, r_x2_c;
    logic [15:0] r_x_a, r_x_b, r_x_c, r_x_d;
    logic        r_n_a, r_n_b, r_n_c, r_n_d;
    logic [11:0] r_t1;
    logic [14:0] r_t2;
    logic [15:0] r_t3;
    logic signed [16:0] r_s;

    logic [31:0] w_sq;
    logic [23:0] w_p1;
    logic [27:0] w_p2;
    logic [30:0] w_p3;
    logic [31:0] w_p4;
    logic [16:0] w_q;
    logic [16:0] w_mag;

    always_comb begin
        w_sq  = 32'(i_x) * 32'(i_x);
        w_p1  = 24'(r_x2_a) * btm_pkg::SINE_K0;
        w_p2  = 28'(r_x2_b) * 28'(r_t1);
        w_p3  = 31'(r_x2_c) * 31'(r_t2);
        w_p4  = 32'(r_x_d) * 32'(r_t3);
        w_q   = w_p4[31:15];
        // Cap at full scale.
        w_mag = (w_q > btm_pkg::SINE_MAX) ? btm_pkg::SINE_MAX : w_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x2_a <= w_sq[30:15];
            r_x_a  <= i_x;
            r_n_a  <= i_neg;
        end
        if (i_en[1]) begin
            r_t1   <= btm_pkg::SINE_K1 - {3'd0, w_p1[23:15]};
            r_x2_b <= r_x2_a;
            r_x_b  <= r_x_a;
            r_n_b  <= r_n_a;
        end
        if (i_en[2]) begin
            r_t2   <= btm_pkg::SINE_K2 - {2'd0, w_p2[27:15]};
            r_x2_c <= r_x2_b;
            r_x_c  <= r_x_b;
            r_n_c  <= r_n_b;
        end
        if (i_en[3]) begin
            r_t3   <= btm_pkg::SINE_K3 - w_p3[30:15];
            r_x_d  <= r_x_c;
            r_n_d  <= r_n_c;
        end
        if (i_en[4]) begin
            r_s <= r_n_d ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_s = r_s;

endmodule

// ===== rtl/btm_mix.sv =====
module btm_mix (
    input  logic                                  i_clk,
    input  logic [btm_pkg::MIX_STAGES-1:0]        i_en,
    input  logic [btm_pkg::NUM_TONES-1:0][16:0]   i_s,
    input  logic                                  i_done,
    input  logic [15:0]                           i_gain,
    output btm_pkg::t_out                         o_out
);

    localparam int PROD_W = btm_pkg::ABS_W + 16;

    logic signed [btm_pkg::SUM_W-1:0] r_sum;
    logic                             r_done_a;
    logic [btm_pkg::MAG_W-1:0]        r_mag;
    logic                             r_neg;
    logic                             r_done_b;
    btm_pkg::t_out                    r_out;

    logic signed [btm_pkg::SUM_W-1:0] w_sum;
    logic [btm_pkg::ABS_W-1:0]        w_abs;
    logic [PROD_W-1:0]                w_prod;
    btm_pkg::t_out                    n_out;

    always_comb begin
        w_sum = '0;
        for (int r = 0; r < btm_pkg::NUM_TONES; r++) begin
            w_sum = w_sum + btm_pkg::SUM_W'($signed(i_s[r]));
        end
    end

    // Divide by eight and apply Q15 gain on the magnitude so it truncates towards zero.
    always_comb begin
        w_abs  = r_sum[btm_pkg::SUM_W-1] ? btm_pkg::ABS_W'(-r_sum) : btm_pkg::ABS_W'(r_sum);
        w_prod = PROD_W'(w_abs) * PROD_W'(i_gain);
    end

    always_comb begin
        n_out.byte_done = r_done_b;
        if (r_neg) begin
            n_out.sample_out = (r_mag > btm_pkg::SAMPLE_MIN) ? $signed(btm_pkg::SAMPLE_MIN)
                                                             : $signed(16'd0 - r_mag);
        end else begin
            n_out.sample_out = (r_mag > btm_pkg::SAMPLE_MAX) ? $signed(btm_pkg::SAMPLE_MAX)
                                                             : $signed(r_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum    <= w_sum;
            r_done_a <= i_done;
        end
        if (i_en[1]) begin
            r_mag    <= w_prod[btm_pkg::GAIN_SHIFT +: btm_pkg::MAG_W];
            r_neg    <= r_sum[btm_pkg::SUM_W-1];
            r_done_b <= r_done_a;
        end
        if (i_en[2]) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/byte_to_multitone_synth_top.sv =====
// A request passes the input, tone, sine, sum, gain and output stages in order before its sample shows on o_out_valid.
// Throughput: one request per clock while the output is not stalled; ten pipeline stages, each with its own valid bit,
// so empty stages fill while the output waits and stalls ripple back only through full ones.
// Reset (synchronous, active low) clears base phase, slot count and stage valids, and
// loads the register defaults: step 0, gain 23198, 44100 samples per byte.
module byte_to_multitone_synth_top #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int COUNT_BITS     = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  btm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output btm_pkg::t_out o_out_data,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    localparam int NS = btm_pkg::NUM_STAGES;

    logic [31:0] r_step;
    logic [15:0] r_gain;
    logic [23:0] r_spb;
    logic [NS-1:0] r_valid;
    logic [btm_pkg::SINE_STAGES-1:0] r_done_d;

    logic [NS-1:0] w_en;
    logic          w_accept;
    logic [btm_pkg::NUM_TONES-1:0][15:0] w_x;
    logic [btm_pkg::NUM_TONES-1:0]       w_neg;
    logic [btm_pkg::NUM_TONES-1:0][16:0] w_s;
    logic          w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= btm_pkg::STEP_RESET;
            r_gain <= btm_pkg::GAIN_RESET;
            r_spb  <= btm_pkg::SPB_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                btm_pkg::CFG_STEP: r_step <= i_cfg_wdata;
                btm_pkg::CFG_GAIN: r_gain <= i_cfg_wdata[15:0];
                btm_pkg::CFG_SPB:  r_spb  <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // A stage may load when empty or when the stage after it moves on.
    always_comb begin
        w_en[NS-1] = !r_valid[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign w_accept   = i_in_valid && w_en[btm_pkg::ST_IN];
    assign o_in_ready = w_en[btm_pkg::ST_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    btm_front #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_en     (w_en[btm_pkg::ST_TONE:btm_pkg::ST_IN]),
        .i_in     (i_in_data),
        .i_step   (r_step),
        .i_spb    (r_spb),
        .o_x      (w_x),
        .o_neg    (w_neg),
        .o_done   (w_done)
    );

    for (genvar g = 0; g < btm_pkg::NUM_TONES; g++) begin : g_lane
        btm_sine u_sine (
            .i_clk (i_clk),
            .i_en  (w_en[btm_pkg::ST_SINE +: btm_pkg::SINE_STAGES]),
            .i_x   (w_x[g]),
            .i_neg (w_neg[g]),
            .o_s   (w_s[g])
        );
    end

    // Carry the slot-end flag alongside the sine lanes.
    always_ff @(posedge i_clk) begin
        if (w_en[btm_pkg::ST_SINE]) begin
            r_done_d[0] <= w_done;
        end
        for (int k = 1; k < btm_pkg::SINE_STAGES; k++) begin
            if (w_en[btm_pkg::ST_SINE + k]) begin
                r_done_d[k] <= r_done_d[k-1];
            end
        end
    end

    btm_mix u_mix (
        .i_clk  (i_clk),
        .i_en   (w_en[btm_pkg::ST_OUT:btm_pkg::ST_SUM]),
        .i_s    (w_s),
        .i_done (r_done_d[btm_pkg::SINE_STAGES-1]),
        .i_gain (r_gain),
        .o_out  (o_out_data)
    );

    assign o_out_valid = r_valid[btm_pkg::ST_OUT];

`include "byte_to_multitone_synth_top_assert.svh"

    `BTM_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, w_accept, r_valid[btm_pkg::ST_IN])
    `BTM_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, (&r_valid) && !i_out_ready, !o_in_ready)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 14;
    localparam int MAX_PRINTED = 40;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [1:0]    reg_idx;
        logic [31:0]   value;
        btm_pkg::t_in  req;
        logic          typed;
        btm_pkg::t_out want;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    btm_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    btm_pkg::t_out o_out_data;
    logic          i_cfg_wr_en = 1'b0;
    logic [1:0]    i_cfg_addr = btm_pkg::CFG_STEP;
    logic [31:0]   i_cfg_wdata = '0;

    // Own copy of the synthesiser state and registers
    logic [31:0] base_phase = '0;
    logic [23:0] slot_count = '0;
    logic [31:0] cfg_step = btm_pkg::STEP_RESET;
    logic [15:0] cfg_gain = btm_pkg::GAIN_RESET;
    logic [23:0] cfg_spb = btm_pkg::SPB_RESET;

    btm_pkg::t_out expected_samples[$];
    t_row dir_rows[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int n_errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_byte_ends = 0;
    int n_saturated = 0;
    int n_cfg_writes = 0;

    byte_to_multitone_synth_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Quarter-wave polynomial, x in Q15 from 0 to 32768
    function automatic int quarter_wave(logic [16:0] x);
        longint unsigned xx, x2, t;
        xx = x;
        x2 = (xx * xx) >> 15;
        t = btm_pkg::SINE_K1 - ((x2 * btm_pkg::SINE_K0) >> 15);
        t = btm_pkg::SINE_K2 - ((x2 * t) >> 15);
        t = btm_pkg::SINE_K3 - ((x2 * t) >> 15);
        t = (xx * t) >> 15;
        return (t > btm_pkg::SINE_MAX) ? int'(btm_pkg::SINE_MAX) : int'(t);
    endfunction

    function automatic int tone_value(logic [31:0] phase);
        logic [9:0] addr;
        logic [8:0] pos;
        int s;
        addr = phase[31:22];
        pos = addr[8] ? 9'd256 - addr[7:0] : {1'b0, addr[7:0]};
        s = quarter_wave({1'b0, pos, 7'd0});
        return addr[9] ? -s : s;
    endfunction

    // Advance the synthesiser by one tick and return the sample it makes
    function automatic btm_pkg::t_out synth_sample(btm_pkg::t_in req);
        btm_pkg::t_out res;
        int mix;
        longint unsigned mag;
        logic [31:0] tone_phase;
        int unsigned mult;
        int unsigned next_count;
        logic [15:0] m16;
        if (req.restart) begin
            base_phase = '0;
            slot_count = '0;
        end
        mix = 0;
        for (int r = 0; r < 8; r++) begin
            mult = 3 + 2 * (2 * r + req.data_byte[7 - r]);
            tone_phase = mult * base_phase;
            mix += tone_value(tone_phase);
        end
        mag = (mix < 0) ? -mix : mix;
        mag = (mag * cfg_gain) >> btm_pkg::GAIN_SHIFT;
        m16 = mag[15:0];
        if (mix < 0) begin
            res.sample_out = (mag > 32768) ? btm_pkg::SAMPLE_MIN : ~m16 + 16'd1;
            if (mag > 32768) n_saturated++;
        end else begin
            res.sample_out = (mag > 32767) ? btm_pkg::SAMPLE_MAX : m16;
            if (mag > 32767) n_saturated++;
        end
        base_phase = base_phase + cfg_step;
        next_count = slot_count + 1;
        if (next_count >= ((cfg_spb == 0) ? 32'd1 : {8'd0, cfg_spb})) begin
            res.byte_done = 1'b1;
            slot_count = '0;
            n_byte_ends++;
        end else begin
            res.byte_done = 1'b0;
            slot_count = next_count[23:0];
        end
        return res;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [31:0] value);
        t_row row;
        row = '{kind: ROW_CFG, reg_idx: idx, value: value, req: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_row req_row(logic [7:0] data, logic restart, logic typed,
                                     logic [15:0] sample, logic done);
        t_row row;
        row.kind = ROW_REQ;
        row.reg_idx = btm_pkg::CFG_STEP;
        row.value = '0;
        row.req.data_byte = data;
        row.req.restart = restart;
        row.typed = typed;
        row.want.sample_out = sample;
        row.want.byte_done = done;
        return row;
    endfunction

    task automatic add_row(t_row row);
        dir_rows = {dir_rows, row};
    endtask

    task automatic report_mismatch(string what, int got, int want);
        if (n_errors < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     n_results, what, got, want);
        n_errors++;
    endtask

    // Present one request, hold it until taken, then queue its expected sample
    task automatic send_req(btm_pkg::t_in req, logic typed, btm_pkg::t_out want);
        btm_pkg::t_out got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        got = synth_sample(req);
        expected_samples = {expected_samples, (typed ? want : got)};
        n_requests++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            btm_pkg::CFG_STEP: cfg_step = value;
            btm_pkg::CFG_GAIN: cfg_gain = value[15:0];
            btm_pkg::CFG_SPB:  cfg_spb = value[23:0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    always @(posedge i_clk) i_out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        btm_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_samples.size() == 0) begin
                report_mismatch("sample with nothing pending", o_out_data.sample_out, 0);
            end else begin
                want = expected_samples.pop_front();
                if (o_out_data.sample_out !== want.sample_out)
                    report_mismatch("sample_out", o_out_data.sample_out, want.sample_out);
                if (o_out_data.byte_done !== want.byte_done)
                    report_mismatch("byte_done", o_out_data.byte_done, want.byte_done);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        int msg_len;
        int hold;
        int sel;
        logic [31:0] wd;
        logic [7:0] data;
        btm_pkg::t_in req;

        // After reset the step is zero, so every tone sits at phase zero
        add_row(req_row(8'h00, 1'b0, 1'b1, 16'sd0, 1'b0));
        add_row(req_row(8'hff, 1'b1, 1'b1, 16'sd0, 1'b0));
        // Zero slot length ends a byte on every sample
        add_row(cfg_row(btm_pkg::CFG_SPB, 32'd0));
        add_row(req_row(8'ha5, 1'b0, 1'b1, 16'sd0, 1'b1));
        add_row(req_row(8'h5a, 1'b0, 1'b1, 16'sd0, 1'b1));
        // Quarter-turn step lands every tone on a peak; gain above unity saturates
        add_row(cfg_row(btm_pkg::CFG_STEP, 32'h4000_0000));
        add_row(cfg_row(btm_pkg::CFG_GAIN, 32'd65535));
        add_row(req_row(8'hff, 1'b1, 1'b1, 16'sd0, 1'b1));
        add_row(req_row(8'h00, 1'b0, 1'b1, -16'sd32768, 1'b1));
        add_row(req_row(8'h55, 1'b0, 1'b1, 16'sd0, 1'b1));
        add_row(req_row(8'h00, 1'b0, 1'b1, 16'sd32767, 1'b1));
        add_row(cfg_row(btm_pkg::CFG_GAIN, 32'd32768));
        add_row(req_row(8'hff, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'hff, 1'b0, 1'b0, '0, 1'b0));
        // Step for 100 Hz at 44.1 kHz, four samples per byte
        add_row(cfg_row(btm_pkg::CFG_STEP, 32'd9739155));
        add_row(cfg_row(btm_pkg::CFG_SPB, 32'd4));
        add_row(req_row(8'h00, 1'b1, 1'b1, 16'sd0, 1'b0));
        add_row(req_row(8'h00, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'hff, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'h81, 1'b0, 1'b0, '0, 1'b0));
        // Zero gain silences everything; longest slot
        add_row(cfg_row(btm_pkg::CFG_GAIN, 32'd0));
        add_row(cfg_row(btm_pkg::CFG_SPB, 32'h00ff_ffff));
        add_row(req_row(8'hff, 1'b1, 1'b1, 16'sd0, 1'b0));
        add_row(req_row(8'h00, 1'b0, 1'b1, 16'sd0, 1'b0));
        // A write to the spare index must leave the gain at zero
        add_row(cfg_row(CFG_UNUSED, 32'hffff_ffff));
        add_row(req_row(8'h3c, 1'b0, 1'b1, 16'sd0, 1'b0));
        add_row(cfg_row(btm_pkg::CFG_GAIN, 32'd23198));
        add_row(cfg_row(btm_pkg::CFG_STEP, 32'hffff_ffff));
        add_row(cfg_row(btm_pkg::CFG_SPB, 32'd10));
        add_row(req_row(8'h12, 1'b1, 1'b0, '0, 1'b0));
        add_row(req_row(8'h34, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'h56, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'h78, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'h9a, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'hbc, 1'b0, 1'b0, '0, 1'b0));
        // Shorten the slot below the count reached: the next sample ends it
        add_row(cfg_row(btm_pkg::CFG_SPB, 32'd3));
        add_row(req_row(8'h7e, 1'b0, 1'b0, '0, 1'b0));
        add_row(req_row(8'he7, 1'b0, 1'b0, '0, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (int round = 0; round < 2; round++) begin
                wait_drained();
                sel = $urandom_range(9);
                wd = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hffff_ffff :
                     (sel == 2) ? 32'd9739155 : $urandom;
                write_reg(btm_pkg::CFG_STEP, wd);
                sel = $urandom_range(9);
                wd = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd32768 : (sel == 2) ? 32'd65535 :
                     (sel <= 4) ? $urandom : $urandom_range(32768);
                write_reg(btm_pkg::CFG_GAIN, wd);
                sel = $urandom_range(9);
                wd = $urandom;
                if (sel == 0) wd[23:0] = '0;
                else if (sel == 1) wd[23:0] = 24'hff_ffff;
                else if (sel > 2) wd = $urandom_range(1, 8);
                write_reg(btm_pkg::CFG_SPB, wd);
                if ($urandom_range(6) == 0) write_reg(CFG_UNUSED, $urandom);

                // Mostly messages of bytes held up to one slot; some loose noise
                sent = 0;
                while (sent < 60) begin
                    if ($urandom_range(99) < 20) begin
                        req.data_byte = $urandom;
                        req.restart = ($urandom_range(9) == 0);
                        send_req(req, 1'b0, '0);
                        sent++;
                    end else begin
                        msg_len = $urandom_range(1, 6);
                        hold = (cfg_spb == 0) ? 1 :
                               (cfg_spb <= 8) ? int'(cfg_spb) : $urandom_range(1, 8);
                        for (int b = 0; b < msg_len; b++) begin
                            data = $urandom;
                            for (int k = 0; k < hold; k++) begin
                                req.data_byte = data;
                                req.restart = (b == 0 && k == 0 && $urandom_range(9) != 0);
                                send_req(req, 1'b0, '0);
                                sent++;
                            end
                        end
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_samples.size() != 0)
            report_mismatch("samples still pending", expected_samples.size(), 0);

        $display("sent %0d requests and checked %0d samples over %0d register writes",
                 n_requests, n_results, n_cfg_writes);
        $display("%0d of them ended a byte slot, %0d were clipped", n_byte_ends, n_saturated);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
